>>> design/qrm_pkg.sv
// shared constants and types for the quaternion to rotation matrix pipeline
// no dependencies
package qrm_pkg;

  localparam int unsigned IN_BITS   = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned NLANE     = 9;
  localparam int unsigned PW        = 2 * IN_BITS;
  localparam int unsigned NW        = PW + 1;
  localparam int unsigned SW        = NW + 1;
  localparam int unsigned QB        = FRAC_BITS + 1;
  localparam int unsigned DSTG      = FRAC_BITS + 1;
  localparam int unsigned IN_DW     = 4 * IN_BITS;
  localparam int unsigned OUT_DW    = NLANE * OUT_W;

  localparam logic [QB:0]      ONE_Q    = (QB + 1)'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] OUT_MAXV = {1'b0, {(OUT_W - 1){1'b1}}};

  typedef logic [NW-1:0] mag_t;
  typedef logic [QB-1:0] quo_t;
  typedef logic signed [SW-1:0] num_t;

endpackage

>>> design/quaternion_to_rotation_matrix.sv
// quaternion to rotation matrix: a registered pipeline from request to result,
// one request accepted every cycle while the result side takes results
// the long part is a restoring divider unrolled to one quotient bit per stage
// reset (async, active low) empties the pipeline; data registers are not reset
// depends on qrm_pkg
module quaternion_to_rotation_matrix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // quat_w, quat_x, quat_y, quat_z
  input  logic [qrm_pkg::IN_DW-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [qrm_pkg::OUT_DW-1:0] m_axis_tdata_o,
  // degenerate
  output logic                      m_axis_tuser_o
);
  import qrm_pkg::*;

  logic en;

  // stage 1: products
  logic signed [IN_BITS-1:0] w, x, y, z;
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic v1_q, zero1_q;

  // stage 2: signed numerators and norm
  num_t num_d [NLANE];
  num_t num_q [NLANE];
  mag_t n2_q;
  logic v2_q, zero2_q;

  // stage 3: sign and magnitude
  mag_t mag_q [NLANE];
  logic neg3_q [NLANE];
  mag_t n3_q;
  logic v3_q, zero3_q;

  // divider stages
  mag_t dr_d [DSTG][NLANE];
  mag_t dr_q [DSTG][NLANE];
  quo_t dq_d [DSTG][NLANE];
  quo_t dq_q [DSTG][NLANE];
  logic dneg_q [DSTG][NLANE];
  mag_t dn_q [DSTG];
  logic dv_q [DSTG];
  logic dz_q [DSTG];

  // output register
  logic [OUT_W-1:0] m_d [NLANE];
  logic [OUT_W-1:0] m_q [NLANE];
  logic ov_q, oz_q;

  assign en = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign w = s_axis_tdata_i[IN_BITS-1:0];
  assign x = s_axis_tdata_i[2*IN_BITS-1:IN_BITS];
  assign y = s_axis_tdata_i[3*IN_BITS-1:2*IN_BITS];
  assign z = s_axis_tdata_i[4*IN_BITS-1:3*IN_BITS];

  function automatic num_t ext(input logic signed [PW-1:0] p);
    return SW'(p);
  endfunction

  always_comb begin
    num_d[0] = (ext(ww_q) + ext(xx_q)) - (ext(yy_q) + ext(zz_q));
    num_d[1] = (ext(xy_q) - ext(wz_q)) <<< 1;
    num_d[2] = (ext(xz_q) + ext(wy_q)) <<< 1;
    num_d[3] = (ext(xy_q) + ext(wz_q)) <<< 1;
    num_d[4] = (ext(ww_q) + ext(yy_q)) - (ext(xx_q) + ext(zz_q));
    num_d[5] = (ext(yz_q) - ext(wx_q)) <<< 1;
    num_d[6] = (ext(xz_q) - ext(wy_q)) <<< 1;
    num_d[7] = (ext(yz_q) + ext(wx_q)) <<< 1;
    num_d[8] = (ext(ww_q) + ext(zz_q)) - (ext(xx_q) + ext(yy_q));
  end

  // one quotient bit per stage
  always_comb begin
    logic [NW:0] rs;
    logic        ge;
    for (int j = 0; j < DSTG; j++) begin
      for (int l = 0; l < NLANE; l++) begin
        if (j == 0) begin
          rs = {1'b0, mag_q[l]};
          ge = rs >= {1'b0, n3_q};
          dq_d[j][l] = quo_t'(ge);
        end else begin
          rs = {dr_q[j-1][l], 1'b0};
          ge = rs >= {1'b0, dn_q[j-1]};
          dq_d[j][l] = {dq_q[j-1][l][QB-2:0], ge};
        end
        if (j == 0) begin
          dr_d[j][l] = ge ? NW'(rs - {1'b0, n3_q}) : NW'(rs);
        end else begin
          dr_d[j][l] = ge ? NW'(rs - {1'b0, dn_q[j-1]}) : NW'(rs);
        end
      end
    end
  end

  // rounding, clamp and sign; identity matrix for a zero quaternion
  always_comb begin
    logic [QB:0]      qr;
    logic [OUT_W-1:0] mg;
    for (int l = 0; l < NLANE; l++) begin
      qr = {1'b0, dq_q[DSTG-1][l]} +
           (QB + 1)'({dr_q[DSTG-1][l], 1'b0} >= {1'b0, dn_q[DSTG-1]});
      if (qr > ONE_Q) qr = ONE_Q;
      mg = OUT_W'(qr);
      if (mg > OUT_MAXV) mg = OUT_MAXV;
      if (dz_q[DSTG-1]) begin
        m_d[l] = (l == 0 || l == 4 || l == 8) ?
                 ((OUT_W'(ONE_Q) > OUT_MAXV) ? OUT_MAXV : OUT_W'(ONE_Q)) : '0;
      end else if (dneg_q[DSTG-1][l] && qr != '0) begin
        m_d[l] = OUT_W'(-mg);
      end else begin
        m_d[l] = mg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
      for (int j = 0; j < DSTG; j++) dv_q[j] <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q[0] <= v3_q;
      for (int j = 1; j < DSTG; j++) dv_q[j] <= dv_q[j-1];
      ov_q <= dv_q[DSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= w * w;
      xx_q <= x * x;
      yy_q <= y * y;
      zz_q <= z * z;
      xy_q <= x * y;
      wz_q <= w * z;
      xz_q <= x * z;
      wy_q <= w * y;
      yz_q <= y * z;
      wx_q <= w * x;
      zero1_q <= (s_axis_tdata_i == '0);

      for (int l = 0; l < NLANE; l++) num_q[l] <= num_d[l];
      n2_q <= NW'(ww_q) + NW'(xx_q) + NW'(yy_q) + NW'(zz_q);
      zero2_q <= zero1_q;

      for (int l = 0; l < NLANE; l++) begin
        neg3_q[l] <= num_q[l][SW-1];
        mag_q[l]  <= num_q[l][SW-1] ? NW'(-num_q[l]) : NW'(num_q[l]);
      end
      n3_q <= n2_q;
      zero3_q <= zero2_q;

      for (int j = 0; j < DSTG; j++) begin
        for (int l = 0; l < NLANE; l++) begin
          dr_q[j][l] <= dr_d[j][l];
          dq_q[j][l] <= dq_d[j][l];
          dneg_q[j][l] <= (j == 0) ? neg3_q[l] : dneg_q[j-1][l];
        end
        dn_q[j] <= (j == 0) ? n3_q : dn_q[j-1];
        dz_q[j] <= (j == 0) ? zero3_q : dz_q[j-1];
      end

      for (int l = 0; l < NLANE; l++) m_q[l] <= m_d[l];
      oz_q <= dz_q[DSTG-1];
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = oz_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) m_axis_tdata_o[l*OUT_W +: OUT_W] = m_q[l];
  end

endmodule

>>> sim/tb_quaternion_to_rotation_matrix.sv
// testbench for quaternion_to_rotation_matrix: drives quaternions on the input stream
// and checks each output matrix against a built-in fixed-point predictor
// depends on qrm_pkg and the quaternion_to_rotation_matrix rtl
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  localparam int NDIR = 14;
  localparam int NRAND = 1800;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [OUT_DW-1:0] mat;
    logic              degen;
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  matrix_t pending_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_degen = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit hold_long = 0;

  logic [IN_DW-1:0] dir_in [NDIR];
  bit               dir_has [NDIR];
  matrix_t          dir_exp [NDIR];

  quaternion_to_rotation_matrix DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int idx, input longint got, input longint want);
    errors++;
    $display("mismatch result %0d %s: got %0d want %0d", idx, what, got, want);
  endtask

  function automatic logic [15:0] to_fixed(input longint num, input longint n);
    longint r;
    longint q;
    bit neg;
    neg = num < 0;
    r = neg ? -num : num;
    q = r / n;
    r = r % n;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= n) begin
        r -= n;
        q |= 1;
      end
    end
    if (2 * r >= n) q++;
    if (q > (longint'(1) << FRAC_BITS)) q = longint'(1) << FRAC_BITS;
    if (q > 32767) q = 32767;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic matrix_t rotation_of(input logic [IN_DW-1:0] d);
    matrix_t m;
    longint w, x, y, z, n;
    longint e [9];
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    m.mat = '0;
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      m.degen = 1'b1;
      for (int i = 0; i < 9; i += 4) m.mat[i*16 +: 16] = 16'(1 << FRAC_BITS);
      return m;
    end
    m.degen = 1'b0;
    n = w*w + x*x + y*y + z*z;
    e[0] = (w*w + x*x) - (y*y + z*z);
    e[1] = 2 * (x*y - w*z);
    e[2] = 2 * (x*z + w*y);
    e[3] = 2 * (x*y + w*z);
    e[4] = (w*w + y*y) - (x*x + z*z);
    e[5] = 2 * (y*z - w*x);
    e[6] = 2 * (x*z - w*y);
    e[7] = 2 * (y*z + w*x);
    e[8] = (w*w + z*z) - (x*x + y*y);
    for (int i = 0; i < 9; i++) m.mat[i*16 +: 16] = to_fixed(e[i], n);
    return m;
  endfunction

  function automatic logic [IN_DW-1:0] pack_q(input int w, x, y, z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'(-$urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      3: return 16'($signed(12'($urandom)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input logic [IN_DW-1:0] d);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_q.push_back(rotation_of(d));
    n_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    matrix_t idm;
    idm.degen = 1'b1;
    idm.mat = '0;
    for (int i = 0; i < 9; i += 4) idm.mat[i*16 +: 16] = 16'(1 << FRAC_BITS);
    for (int i = 0; i < NDIR; i++) dir_has[i] = 0;
    dir_in[0] = '0;                          dir_has[0] = 1; dir_exp[0] = idm;
    dir_in[1] = pack_q(1, 0, 0, 0);          dir_has[1] = 1;
    dir_exp[1] = idm; dir_exp[1].degen = 1'b0;
    dir_in[2] = pack_q(32767, 0, 0, 0);      dir_has[2] = 1; dir_exp[2] = dir_exp[1];
    dir_in[3] = pack_q(-32768, 0, 0, 0);     dir_has[3] = 1; dir_exp[3] = dir_exp[1];
    dir_in[4] = pack_q(0, 32767, 0, 0);
    dir_in[5] = pack_q(0, 0, -32768, 0);
    dir_in[6] = pack_q(0, 0, 0, 1);
    dir_in[7] = pack_q(-32768, -32768, -32768, -32768);
    dir_in[8] = pack_q(32767, 32767, 32767, 32767);
    dir_in[9] = pack_q(32767, -32768, 32767, -32768);
    dir_in[10] = pack_q(1, 1, 0, 0);
    dir_in[11] = pack_q(-1, 0, 1, -1);
    dir_in[12] = pack_q(3, 5, -7, 11);
    dir_in[13] = '0;                         dir_has[13] = 1; dir_exp[13] = idm;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NDIR; i++) begin
      send(dir_in[i]);
      if (dir_has[i] && pending_q[$] != dir_exp[i]) begin
        report("predictor table row", i, 0, 0);
      end
    end
    hold_long = 1;
    for (int i = 0; i < 60; i++) send(pack_q(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    hold_long = 0;
    for (int i = 0; i < NRAND; i++) begin
      send($urandom_range(0, 40) == 0 ? '0 :
           pack_q(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int stall;
    bit held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long && !held) begin
        m_axis_tready_i <= 1'b0;
        stall = 0;
        while (stall < 80) begin
          @(negedge clk_i);
          stall++;
        end
        held = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 1)) repeat ($urandom_range(5, 30)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    matrix_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", n_got, 0, 0);
      end else begin
        want = pending_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_axis_tdata_o[i*16 +: 16] !== want.mat[i*16 +: 16])
            report($sformatf("entry m%0d%0d", i / 3, i % 3), n_got,
                   $signed(m_axis_tdata_o[i*16 +: 16]), $signed(want.mat[i*16 +: 16]));
        end
        if (m_axis_tuser_o !== want.degen)
          report("degenerate", n_got, m_axis_tuser_o, want.degen);
        if (want.degen) n_degen++;
      end
      n_got++;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_q.size() != 0) report("results left over", pending_q.size(), 0, 0);
    $display("sent %0d quaternions, checked %0d matrices (%0d zero quaternions)",
             n_sent, n_got, n_degen);
    $display("random gaps and stalls on both sides, one long output hold-off");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
